### hw/rtl/srf_pkg.sv
package srf_pkg;

  localparam int ROW_WIDTH_DFLT = 64;
  localparam int LANE_W         = 8;
  localparam int PIX_W          = 64;
  localparam int COL_W          = 6;

  typedef struct packed {
    logic [LANE_W-1:0] pix;
    logic [LANE_W-1:0] epre;
    logic [LANE_W-1:0] esuf;
    logic [LANE_W-1:0] tpre;
    logic              eany;
  } lane_res_t;

endpackage

### hw/rtl/srf_lane.sv
module srf_lane #(
  parameter int ROW_WIDTH = srf_pkg::ROW_WIDTH_DFLT,
  parameter int BASE      = 0
) (
  input  logic                      clk,
  input  logic [srf_pkg::LANE_W+1:0] seg_i,
  output srf_pkg::lane_res_t        res_o
);

  localparam int LW = srf_pkg::LANE_W;

  logic [LW-1:0]      edg;
  logic [LW-1:0]      crs;
  srf_pkg::lane_res_t res_nxt;
  srf_pkg::lane_res_t res_r;

  always_comb begin
    logic par_e;
    logic par_t;
    logic any_e;
    for (int j = 0; j < LW; j++) begin
      edg[j] = seg_i[j+1] & ~seg_i[j+2] & ((BASE + j) < (ROW_WIDTH - 1));
      crs[j] = seg_i[j+1] & (~seg_i[j] | ~seg_i[j+2]);
    end
    par_e = 1'b0;
    par_t = 1'b0;
    for (int j = 0; j < LW; j++) begin
      par_e            = par_e ^ edg[j];
      par_t            = par_t ^ crs[j];
      res_nxt.epre[j]  = par_e;
      res_nxt.tpre[j]  = par_t;
    end
    any_e = 1'b0;
    for (int j = LW - 1; j >= 0; j--) begin
      res_nxt.esuf[j] = any_e;
      any_e           = any_e | edg[j];
    end
    res_nxt.eany = any_e;
    res_nxt.pix  = seg_i[LW:1];
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_o = res_r;

endmodule

### hw/rtl/srf_merge.sv
module srf_merge #(
  parameter int ROW_WIDTH = srf_pkg::ROW_WIDTH_DFLT
) (
  input  logic                            clk,
  input  srf_pkg::lane_res_t              lane_res_i [(ROW_WIDTH+srf_pkg::LANE_W-1)/srf_pkg::LANE_W],
  input  logic [srf_pkg::COL_W-1:0]       col_i,
  output logic [srf_pkg::PIX_W-1:0]       filled_o,
  output logic                            flag_o
);

  localparam int LW        = srf_pkg::LANE_W;
  localparam int NUM_LANES = (ROW_WIDTH + LW - 1) / LW;
  localparam int PAD       = NUM_LANES * LW;
  localparam int IDX_W     = $clog2(PAD);

  logic [NUM_LANES-1:0]       carry_par;
  logic [NUM_LANES-1:0]       carry_t;
  logic [NUM_LANES-1:0]       later_any;
  logic [PAD-1:0]             fill_v;
  logic [PAD-1:0]             tp_v;
  logic [srf_pkg::PIX_W-1:0]  filled_nxt;
  logic                       flag_nxt;
  logic [srf_pkg::PIX_W-1:0]  filled_r;
  logic                       flag_r;

  always_comb begin
    logic ep_run;
    logic tp_run;
    logic any_run;
    ep_run  = 1'b0;
    tp_run  = 1'b0;
    for (int l = 0; l < NUM_LANES; l++) begin
      carry_par[l] = ep_run;
      carry_t[l]   = tp_run;
      ep_run       = ep_run ^ lane_res_i[l].epre[LW-1];
      tp_run       = tp_run ^ lane_res_i[l].tpre[LW-1];
    end
    any_run = 1'b0;
    for (int l = NUM_LANES - 1; l >= 0; l--) begin
      later_any[l] = any_run;
      any_run      = any_run | lane_res_i[l].eany;
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      for (int j = 0; j < LW; j++) begin
        fill_v[l*LW+j] = lane_res_i[l].pix[j]
                       | ((carry_par[l] ^ lane_res_i[l].epre[j])
                          & (lane_res_i[l].esuf[j] | later_any[l]));
        tp_v[l*LW+j]   = carry_t[l] ^ lane_res_i[l].tpre[j];
      end
    end
    filled_nxt = srf_pkg::PIX_W'(fill_v);
    if ({1'b0, col_i} < (srf_pkg::COL_W+1)'(PAD)) begin
      flag_nxt = tp_v[col_i[IDX_W-1:0]];
    end else begin
      flag_nxt = tp_v[PAD-1];
    end
  end

  always_ff @(posedge clk) begin
    filled_r <= filled_nxt;
    flag_r   <= flag_nxt;
  end

  assign filled_o = filled_r;
  assign flag_o   = flag_r;

endmodule

### hw/rtl/scanline_row_fill.sv
// Channel   Ports                                     Transaction
// input     start, busy, in_row_pixels, in_query_col  start && !busy at clk edge
// result    out_valid, out_filled_row, out_inside_flag one cycle, out_valid high
//
// One row per clock; each input transaction is registered in the lane stage,
// then in the merge stage, whose registers present its result.
// busy stays low: both stages advance every cycle.
// rst_n (synchronous, active low) clears the valid pipeline only.
// The receiver cannot stall; results are presented for one cycle.
module scanline_row_fill #(
  parameter int ROW_WIDTH = srf_pkg::ROW_WIDTH_DFLT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [srf_pkg::PIX_W-1:0]   in_row_pixels,
  input  logic [srf_pkg::COL_W-1:0]   in_query_col,
  output logic                        out_valid,
  output logic [srf_pkg::PIX_W-1:0]   out_filled_row,
  output logic                        out_inside_flag
);

  localparam int LW        = srf_pkg::LANE_W;
  localparam int NUM_LANES = (ROW_WIDTH + LW - 1) / LW;
  localparam int PAD       = NUM_LANES * LW;

  logic [PAD-1:0]              row_pad;
  logic [PAD+1:0]              row_ext;
  srf_pkg::lane_res_t          lane_res [NUM_LANES];
  logic [srf_pkg::COL_W-1:0]   col_r;
  logic                        v1_r;
  logic                        v1_nxt;
  logic                        v2_r;
  logic                        v2_nxt;
  logic                        accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  for (genvar j = 0; j < PAD; j++) begin : g_pad
    if (j < ROW_WIDTH) begin : g_in
      assign row_pad[j] = in_row_pixels[j];
    end else begin : g_zero
      assign row_pad[j] = 1'b0;
    end
  end

  assign row_ext = {1'b0, row_pad, 1'b0};

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    srf_lane #(
      .ROW_WIDTH (ROW_WIDTH),
      .BASE      (l * LW)
    ) u_lane (
      .clk   (clk),
      .seg_i (row_ext[l*LW +: LW+2]),
      .res_o (lane_res[l])
    );
  end

  srf_merge #(
    .ROW_WIDTH (ROW_WIDTH)
  ) u_merge (
    .clk        (clk),
    .lane_res_i (lane_res),
    .col_i      (col_r),
    .filled_o   (out_filled_row),
    .flag_o     (out_inside_flag)
  );

  assign v1_nxt = accept;
  assign v2_nxt = v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= in_query_col;
  end

  assign out_valid = v2_r;

  a_valid_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result without a matching input transaction");

  a_fill_covers_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_filled_row & $past(srf_pkg::PIX_W'(row_pad), 2))
                   == $past(srf_pkg::PIX_W'(row_pad), 2)))
    else $error("filled row dropped an input pixel");

  a_col0_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_query_col, 2) == '0))
      |-> (out_inside_flag == $past(row_pad[0], 2)))
    else $error("inside flag at column 0 disagrees with pixel 0");

endmodule
